// ----- hdl/dctr_pkg.sv -----
// Package with the shared types, constants and ring helper functions of the timer ring.
`default_nettype none

package dctr_pkg;

    localparam int NUM_SHARDS = 8;
    localparam int RING_DEPTH = 64;

    localparam int SHARD_W   = (NUM_SHARDS > 1) ? $clog2(NUM_SHARDS) : 1;
    localparam int SLOT_W    = $clog2(RING_DEPTH);
    localparam int PTR_W     = $clog2(2 * RING_DEPTH);
    localparam int MEM_DEPTH = NUM_SHARDS * RING_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(2 * RING_DEPTH - 1);
    localparam logic [PTR_W:0]   PTR_MOD   = (PTR_W + 1)'(2 * RING_DEPTH);
    localparam logic [PTR_W-1:0] RING_FULL = PTR_W'(RING_DEPTH);

    localparam logic [31:0] SHARD_LIMIT = 32'(NUM_SHARDS);

    localparam int PPM_W  = 20;
    localparam int ROLL_W = 21;
    localparam logic [31:0]       PPM_SCALE  = 32'd1000000;
    localparam logic [ROLL_W-1:0] PPM_ROLL   = ROLL_W'(1000000);

    // The roll is divided by 64 first, then by 15625 through a reciprocal scaled by 2^40.
    localparam int RECIP_W   = 27;
    localparam int RSHIFT    = 40;
    localparam int PROD_W    = 53;
    localparam int QUOT_W    = PROD_W - RSHIFT;
    localparam logic [RECIP_W-1:0] RECIP = 27'd70368744;

    localparam logic [31:0] LFSR_TAPS = 32'hD000_0001;
    localparam logic [31:0] LFSR_SEED = 32'h0000_0001;

    localparam logic KIND_ISSUE    = 1'b0;
    localparam logic KIND_POLL     = 1'b1;
    localparam logic RK_STATUS     = 1'b0;
    localparam logic RK_COMPLETION = 1'b1;

    localparam logic [2:0] CFG_READ_LATENCY = 3'd0;
    localparam logic [2:0] CFG_DROP_PPM     = 3'd1;
    localparam logic [2:0] CFG_ERROR_PPM    = 3'd2;
    localparam logic [2:0] CFG_NS_COUNT     = 3'd3;
    localparam logic [2:0] CFG_NS_MASK      = 3'd4;

    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_IDX_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_SHARD = 2'd1,
        ST_FULL      = 2'd2,
        ST_IO_ERR    = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_ISSUE,
        BK_CHECK,
        BK_READ,
        BK_MUL,
        BK_REM,
        BK_CLASS,
        BK_EMIT,
        BK_FLUSH
    } back_state_t;

    // The stamp is the due time for an issue and the current time for a poll.
    typedef struct packed {
        logic               kind;
        logic [SHARD_W-1:0] shard;
        logic               shard_bad;
        logic               ns_bad;
        logic [63:0]        cookie;
        logic [63:0]        stamp;
    } cmd_t;

    typedef struct packed {
        logic [31:0] latency;
        logic [5:0]  ns_count;
        logic [31:0] ns_mask;
    } issue_cfg_t;

    typedef struct packed {
        logic [PPM_W-1:0] drop_ppm;
        logic [PPM_W-1:0] error_ppm;
    } fault_cfg_t;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [SLOT_W-1:0] slot_of(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] s;
        s = (p >= RING_FULL) ? p - RING_FULL : p;
        return s[SLOT_W-1:0];
    endfunction

    function automatic logic [PTR_W-1:0] ring_used(input logic [PTR_W-1:0] head,
                                                    input logic [PTR_W-1:0] tail);
        logic [PTR_W:0] d;
        d = {1'b0, tail} + PTR_MOD - {1'b0, head};
        if (d >= PTR_MOD) begin
            d = d - PTR_MOD;
        end
        return d[PTR_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] ring_addr(input logic [SHARD_W-1:0] shard,
                                                    input logic [SLOT_W-1:0] slot);
        return ADDR_W'(shard) * ADDR_W'(RING_DEPTH) + ADDR_W'(slot);
    endfunction

endpackage

`default_nettype wire

// ----- hdl/deferred_completion_timer_ring.sv -----
// Top level of the deferred completion timer ring with its configuration registers.
//
// Input items arrive on the in channel: an issue (kind 0) pushes a due time of now_ns
// plus the read latency and a cookie into the ring of the shard named by cookie[63:32]
// and returns one status item; a poll (kind 1) drains the due head entries of poll_shard.
// Result items leave on the out channel, the last one of each input item marked by last.
// Registers are written on the cfg channel, which is always ready.
// The front end accepts an item into a two-entry command queue, so input
// items keep being taken while the ring engine works or the receiver stalls, until the
// queue is full and in_ready drops.
// An issue passes the command queue, the command register and the result register.
// A poll takes each head entry through the check and read states and each delivered
// completion through the emit state, ending in the flush state, bounded by the single
// read port of the entry memory; with a nonzero drop or error rate each drained entry
// also passes the multiply, remainder and classify states for the roll reduction.
// A stalled receiver holds the result register, and the engine waits behind it.
// Reset clears the ring pointers, seeds the roll generator with one and zeroes the
// configuration; the entry memory needs no clearing.
`default_nettype none

module deferred_completion_timer_ring
    import dctr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        kind,
    input  wire logic [63:0] now_ns,
    input  wire logic [63:0] cookie,
    input  wire logic [7:0]  namespace_id,
    input  wire logic [2:0]  poll_shard,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             result_kind,
    output logic [1:0]       status,
    output logic [63:0]      done_cookie,
    output logic             last,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    logic [31:0]      latency_reg;
    logic [PPM_W-1:0] drop_reg;
    logic [PPM_W-1:0] error_reg;
    logic [5:0]       ns_count_reg;
    logic [31:0]      ns_mask_reg;

    issue_cfg_t icfg;
    fault_cfg_t fcfg;
    logic       push_valid;
    logic       push_ready;
    cmd_t       push_cmd;
    logic       pop_valid;
    logic       pop_ready;
    cmd_t       pop_cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latency_reg  <= '0;
            drop_reg     <= '0;
            error_reg    <= '0;
            ns_count_reg <= '0;
            ns_mask_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_READ_LATENCY: latency_reg  <= cfg_data;
                CFG_DROP_PPM:     drop_reg     <= cfg_data[PPM_W-1:0];
                CFG_ERROR_PPM:    error_reg    <= cfg_data[PPM_W-1:0];
                CFG_NS_COUNT:     ns_count_reg <= cfg_data[5:0];
                CFG_NS_MASK:      ns_mask_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign icfg.latency   = latency_reg;
    assign icfg.ns_count  = ns_count_reg;
    assign icfg.ns_mask   = ns_mask_reg;
    assign fcfg.drop_ppm  = drop_reg;
    assign fcfg.error_ppm = error_reg;

    dctr_front u_front (
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .now_ns       (now_ns),
        .cookie       (cookie),
        .namespace_id (namespace_id),
        .poll_shard   (poll_shard),
        .icfg         (icfg),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_cmd     (push_cmd)
    );

    dctr_cmd_fifo u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    dctr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (pop_valid),
        .q_pop       (pop_ready),
        .q_cmd       (pop_cmd),
        .fcfg        (fcfg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_kind (result_kind),
        .status      (status),
        .done_cookie (done_cookie),
        .last        (last)
    );

endmodule

`default_nettype wire

// ----- hdl/dctr_front.sv -----
// Front end that accepts items, runs the configuration checks and forms queue commands.
`default_nettype none

module dctr_front
    import dctr_pkg::*;
(
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        kind,
    input  wire logic [63:0] now_ns,
    input  wire logic [63:0] cookie,
    input  wire logic [7:0]  namespace_id,
    input  wire logic [2:0]  poll_shard,
    input  wire issue_cfg_t  icfg,
    output logic             push_valid,
    input  wire logic        push_ready,
    output cmd_t             push_cmd
);

    logic [31:0] shard_wide;
    logic [31:0] poll_wide;
    logic        shard_bad;
    logic        ns_bad;
    logic        poll_ok;

    assign shard_wide = cookie[63:32];
    assign poll_wide  = {29'd0, poll_shard};
    assign shard_bad  = (shard_wide >= SHARD_LIMIT);
    assign poll_ok    = (poll_wide < SHARD_LIMIT);

    // Ids of 32 and above have no mask bit and count as unmapped.
    assign ns_bad = (namespace_id >= {2'b00, icfg.ns_count})
                 || (namespace_id[7:5] != 3'd0)
                 || !icfg.ns_mask[namespace_id[4:0]];

    assign in_ready   = push_ready;
    assign push_valid = in_valid && ((kind == KIND_ISSUE) || poll_ok);

    always_comb
    begin
        push_cmd.kind      = kind;
        push_cmd.shard_bad = shard_bad;
        push_cmd.ns_bad    = ns_bad;
        push_cmd.cookie    = cookie;
        if (kind == KIND_ISSUE)
        begin
            push_cmd.shard = shard_bad ? '0 : shard_wide[SHARD_W-1:0];
            push_cmd.stamp = now_ns + {32'd0, icfg.latency};
        end
        else
        begin
            push_cmd.shard = poll_wide[SHARD_W-1:0];
            push_cmd.stamp = now_ns;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/dctr_cmd_fifo.sv -----
// Short command queue between the front end and the ring engine.
`default_nettype none

module dctr_cmd_fifo
    import dctr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    output logic      push_ready,
    input  wire cmd_t push_cmd,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output cmd_t      pop_cmd
);

    cmd_t                  entry_reg [CMDQ_DEPTH];
    logic [CMDQ_IDX_W-1:0] wr_ptr_reg;
    logic [CMDQ_IDX_W-1:0] rd_ptr_reg;
    logic [CMDQ_CNT_W-1:0] count_reg;
    logic                  do_push;
    logic                  do_pop;

    assign push_ready = (count_reg != CMDQ_CNT_W'(CMDQ_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == CMDQ_IDX_W'(CMDQ_DEPTH - 1)) ? '0
                                                                         : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == CMDQ_IDX_W'(CMDQ_DEPTH - 1)) ? '0
                                                                         : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/dctr_back.sv -----
// Ring engine holding the entry memory, ring pointers, fault roll and the result register.
`default_nettype none

module dctr_back
    import dctr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_valid,
    output logic             q_pop,
    input  wire cmd_t        q_cmd,
    input  wire fault_cfg_t  fcfg,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             result_kind,
    output logic [1:0]       status,
    output logic [63:0]      done_cookie,
    output logic             last
);

    back_state_t state_reg;
    back_state_t state_next;
    cmd_t        cmd_reg;

    logic [PTR_W-1:0] head_reg [NUM_SHARDS];
    logic [PTR_W-1:0] tail_reg [NUM_SHARDS];
    logic [31:0]      lfsr_reg;

    logic [63:0] due_mem [MEM_DEPTH];
    logic [63:0] ck_mem  [MEM_DEPTH];
    logic [63:0] rd_due_reg;
    logic [63:0] rd_ck_reg;

    logic [PROD_W-1:0] prod_reg;
    logic [ROLL_W-1:0] rem_reg;
    logic [63:0]       cur_ck_reg;
    status_t           cur_st_reg;
    logic              pend_valid_reg;
    logic [63:0]       pend_ck_reg;
    status_t           pend_st_reg;

    logic        out_valid_reg;
    logic        out_kind_reg;
    status_t     out_st_reg;
    logic [63:0] out_ck_reg;
    logic        out_last_reg;

    logic [PTR_W-1:0]  head_cur;
    logic [PTR_W-1:0]  tail_cur;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    status_t           issue_st;
    logic              out_free;
    logic              fault_on;
    logic              late;
    logic [QUOT_W-1:0] quot;
    logic [31:0]       quot_scaled;
    logic [ROLL_W-1:0] roll_full;
    logic [ROLL_W-1:0] err_limit;
    logic              roll_drop;
    logic              roll_err;

    logic        out_load;
    logic        load_kind;
    status_t     load_st;
    logic [63:0] load_ck;
    logic        load_last;
    logic        mem_we;
    logic        rd_en;
    logic        tail_inc;
    logic        head_inc;
    logic        lfsr_step;
    logic        prod_en;
    logic        rem_en;
    logic        cur_st_we;
    status_t     cur_st_val;
    logic        pend_load;
    logic        pend_clear;

    assign head_cur = head_reg[cmd_reg.shard];
    assign tail_cur = tail_reg[cmd_reg.shard];
    assign wr_addr  = ring_addr(cmd_reg.shard, slot_of(tail_cur));
    assign rd_addr  = ring_addr(cmd_reg.shard, slot_of(head_cur));
    assign out_free = !out_valid_reg || out_ready;
    assign fault_on = (fcfg.drop_ppm != '0) || (fcfg.error_ppm != '0);
    assign late     = (rd_due_reg > cmd_reg.stamp);

    always_comb
    begin
        if (cmd_reg.shard_bad)
        begin
            issue_st = ST_BAD_SHARD;
        end
        else if (ring_used(head_cur, tail_cur) >= RING_FULL)
        begin
            issue_st = ST_FULL;
        end
        else if (cmd_reg.ns_bad)
        begin
            issue_st = ST_IO_ERR;
        end
        else
        begin
            issue_st = ST_OK;
        end
    end

    // The quotient estimate is exact or one short, so one conditional subtract finishes it.
    assign quot        = prod_reg[PROD_W-1:RSHIFT];
    assign quot_scaled = {{(32 - QUOT_W){1'b0}}, quot} * PPM_SCALE;
    assign roll_full   = (rem_reg >= PPM_ROLL) ? rem_reg - PPM_ROLL : rem_reg;
    assign err_limit   = {1'b0, fcfg.drop_ppm} + {1'b0, fcfg.error_ppm};
    assign roll_drop   = (roll_full < {1'b0, fcfg.drop_ppm});
    assign roll_err    = (roll_full < err_limit);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = (q_cmd.kind == KIND_ISSUE) ? BK_ISSUE : BK_CHECK;
                end
            end
            BK_ISSUE:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_CHECK:
            begin
                state_next = (head_cur == tail_cur) ? BK_FLUSH : BK_READ;
            end
            BK_READ:
            begin
                if (late)
                begin
                    state_next = BK_FLUSH;
                end
                else
                begin
                    state_next = fault_on ? BK_MUL : BK_EMIT;
                end
            end
            BK_MUL:
            begin
                state_next = BK_REM;
            end
            BK_REM:
            begin
                state_next = BK_CLASS;
            end
            BK_CLASS:
            begin
                state_next = roll_drop ? BK_CHECK : BK_EMIT;
            end
            BK_EMIT:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    state_next = BK_CHECK;
                end
            end
            BK_FLUSH:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // A drained completion waits in the pending slot until the next one or the end of the
    // poll decides its last mark.
    always_comb
    begin
        q_pop      = 1'b0;
        out_load   = 1'b0;
        load_kind  = RK_COMPLETION;
        load_st    = pend_st_reg;
        load_ck    = pend_ck_reg;
        load_last  = 1'b0;
        mem_we     = 1'b0;
        rd_en      = 1'b0;
        tail_inc   = 1'b0;
        head_inc   = 1'b0;
        lfsr_step  = 1'b0;
        prod_en    = 1'b0;
        rem_en     = 1'b0;
        cur_st_we  = 1'b0;
        cur_st_val = ST_OK;
        pend_load  = 1'b0;
        pend_clear = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                q_pop = q_valid;
            end
            BK_ISSUE:
            begin
                if (out_free)
                begin
                    out_load  = 1'b1;
                    load_kind = RK_STATUS;
                    load_st   = issue_st;
                    load_ck   = cmd_reg.cookie;
                    load_last = 1'b1;
                    mem_we    = (issue_st == ST_OK);
                    tail_inc  = (issue_st == ST_OK);
                end
            end
            BK_CHECK:
            begin
                rd_en = (head_cur != tail_cur);
            end
            BK_READ:
            begin
                if (!late)
                begin
                    head_inc  = 1'b1;
                    lfsr_step = fault_on;
                    cur_st_we = !fault_on;
                end
            end
            BK_MUL:
            begin
                prod_en = 1'b1;
            end
            BK_REM:
            begin
                rem_en = 1'b1;
            end
            BK_CLASS:
            begin
                cur_st_we  = 1'b1;
                cur_st_val = roll_err ? ST_IO_ERR : ST_OK;
            end
            BK_EMIT:
            begin
                if (!pend_valid_reg)
                begin
                    pend_load = 1'b1;
                end
                else if (out_free)
                begin
                    out_load  = 1'b1;
                    pend_load = 1'b1;
                end
            end
            BK_FLUSH:
            begin
                if (pend_valid_reg && out_free)
                begin
                    out_load   = 1'b1;
                    load_last  = 1'b1;
                    pend_clear = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            due_mem[wr_addr] <= cmd_reg.stamp;
            ck_mem[wr_addr]  <= cmd_reg.cookie;
        end
        if (rd_en)
        begin
            rd_due_reg <= due_mem[rd_addr];
            rd_ck_reg  <= ck_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg <= q_cmd;
        end
        if (prod_en)
        begin
            prod_reg <= {{(PROD_W - 26){1'b0}}, lfsr_reg[31:6]}
                      * {{(PROD_W - RECIP_W){1'b0}}, RECIP};
        end
        if (rem_en)
        begin
            rem_reg <= ROLL_W'(lfsr_reg - quot_scaled);
        end
        if (head_inc)
        begin
            cur_ck_reg <= rd_ck_reg;
        end
        if (cur_st_we)
        begin
            cur_st_reg <= cur_st_val;
        end
        if (pend_load)
        begin
            pend_ck_reg <= cur_ck_reg;
            pend_st_reg <= cur_st_reg;
        end
        if (out_load)
        begin
            out_kind_reg <= load_kind;
            out_st_reg   <= load_st;
            out_ck_reg   <= load_ck;
            out_last_reg <= load_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            lfsr_reg       <= LFSR_SEED;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < NUM_SHARDS; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (lfsr_step)
            begin
                lfsr_reg <= {1'b0, lfsr_reg[31:1]} ^ (lfsr_reg[0] ? LFSR_TAPS : '0);
            end
            if (head_inc)
            begin
                head_reg[cmd_reg.shard] <= ptr_next(head_cur);
            end
            if (tail_inc)
            begin
                tail_reg[cmd_reg.shard] <= ptr_next(tail_cur);
            end
            if (pend_load)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (pend_clear)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = out_kind_reg;
    assign status      = out_st_reg;
    assign done_cookie = out_ck_reg;
    assign last        = out_last_reg;

endmodule

`default_nettype wire

// ----- hdl/dctr_checker.sv -----
// Port-level checker for the timer ring and its bind to the top level.
`default_nettype none

module dctr_checker
    import dctr_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        kind,
    input wire logic [63:0] now_ns,
    input wire logic [63:0] cookie,
    input wire logic [7:0]  namespace_id,
    input wire logic [2:0]  poll_shard,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        result_kind,
    input wire logic [1:0]  status,
    input wire logic [63:0] done_cookie,
    input wire logic        last,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready,
    input wire logic [2:0]  cfg_index,
    input wire logic [31:0] cfg_data
);

    // An issue item always has exactly one result, so its status is final.
    a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == RK_STATUS) |-> last)
        else $error("issue status item without last mark");

    // Completions carry only the ok or io error codes.
    a_completion_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == RK_COMPLETION) |-> (status == ST_OK)
                                                     || (status == ST_IO_ERR))
        else $error("completion item with an issue-only status");

    // An invalid shard status must echo a cookie whose shard is out of range.
    a_bad_shard_cookie: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == RK_STATUS) && (status == ST_BAD_SHARD)
        |-> (done_cookie[63:32] >= SHARD_LIMIT))
        else $error("invalid shard status for an in-range shard");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(done_cookie) && $stable(status)
                                    && $stable(last) && $stable(result_kind))
        else $error("result item changed while stalled");

endmodule

bind deferred_completion_timer_ring dctr_checker u_dctr_checker (.*);

`default_nettype wire

// ----- dv/tb_deferred_completion_timer_ring.sv -----
// Self-checking testbench for the deferred completion timer ring with a cycle-free ring predictor.
module tb_deferred_completion_timer_ring;
    timeunit 1ns;
    timeprecision 1ps;

    import dctr_pkg::*;

    localparam int IDLE_LIMIT      = 5000;
    localparam int DRAIN_CYCLES    = 1000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int MAX_REPORTS     = 10;
    localparam logic [31:0] ROLL_TAPS = 32'hD000_0001;
    localparam logic [31:0] PPM_RANGE = 32'd1_000_000;
    localparam logic [63:0] TIME_MAX  = '1;

    typedef struct {
        logic        kind;
        logic [63:0] now;
        logic [63:0] tag;
        logic [7:0]  nsid;
        logic [2:0]  shard;
    } ring_req_t;

    typedef struct {
        logic        rkind;
        status_t     st;
        logic [63:0] tag;
        logic        fin;
    } ring_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        kind;
    logic [63:0] now_ns;
    logic [63:0] cookie;
    logic [7:0]  namespace_id;
    logic [2:0]  poll_shard;
    logic        out_valid;
    logic        out_ready;
    logic        result_kind;
    logic [1:0]  status;
    logic [63:0] done_cookie;
    logic        last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    logic [63:0]      due_mem [NUM_SHARDS][RING_DEPTH];
    logic [63:0]      tag_mem [NUM_SHARDS][RING_DEPTH];
    logic [PTR_W-1:0] head_q [NUM_SHARDS];
    logic [PTR_W-1:0] tail_q [NUM_SHARDS];
    logic [31:0]      roll_state;
    logic [31:0]      lat_cfg;
    logic [19:0]      drop_cfg;
    logic [19:0]      err_cfg;
    logic [5:0]       ns_count_cfg;
    logic [31:0]      ns_mask_cfg;

    ring_result_t awaited_results [$];
    int           mismatches = 0;
    int           idle_cycles = 0;
    int           hold_off_cycles = 0;
    bit           no_gaps = 1'b0;
    logic [63:0]  sim_ns;

    deferred_completion_timer_ring u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .now_ns       (now_ns),
        .cookie       (cookie),
        .namespace_id (namespace_id),
        .poll_shard   (poll_shard),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_kind  (result_kind),
        .status       (status),
        .done_cookie  (done_cookie),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void note_failure(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endfunction

    function automatic void predict_ring_results(input ring_req_t r);
        ring_result_t     res;
        ring_result_t     batch [$];
        logic [PTR_W-1:0] used;
        int               s;
        int               slot;
        logic             lsb;
        logic [31:0]      roll;
        res.rkind = RK_STATUS;
        res.st    = ST_OK;
        res.tag   = r.tag;
        res.fin   = 1'b1;
        if (r.kind == KIND_ISSUE) begin
            if (r.tag[63:32] >= NUM_SHARDS) begin
                res.st = ST_BAD_SHARD;
            end else begin
                s    = int'(r.tag[63:32]);
                used = tail_q[s] - head_q[s];
                if (used >= RING_DEPTH) begin
                    res.st = ST_FULL;
                end else if (r.nsid >= ns_count_cfg || r.nsid >= 8'd32
                             || !ns_mask_cfg[r.nsid[4:0]]) begin
                    res.st = ST_IO_ERR;
                end else begin
                    slot             = tail_q[s] % RING_DEPTH;
                    due_mem[s][slot] = r.now + 64'(lat_cfg);
                    tag_mem[s][slot] = r.tag;
                    tail_q[s]        = tail_q[s] + 1'b1;
                end
            end
            awaited_results.push_back(res);
        end else if (r.shard < NUM_SHARDS) begin
            s = int'(r.shard);
            while (head_q[s] != tail_q[s] && batch.size() < RING_DEPTH) begin
                slot = head_q[s] % RING_DEPTH;
                if (due_mem[s][slot] > r.now) begin
                    break;
                end
                res.rkind = RK_COMPLETION;
                res.st    = ST_OK;
                res.tag   = tag_mem[s][slot];
                res.fin   = 1'b0;
                head_q[s] = head_q[s] + 1'b1;
                if (drop_cfg != 0 || err_cfg != 0) begin
                    lsb        = roll_state[0];
                    roll_state = roll_state >> 1;
                    if (lsb) begin
                        roll_state = roll_state ^ ROLL_TAPS;
                    end
                    roll = roll_state % PPM_RANGE;
                    if (roll < drop_cfg) begin
                        continue;
                    end
                    if (roll < 32'(drop_cfg) + 32'(err_cfg)) begin
                        res.st = ST_IO_ERR;
                    end
                end
                batch.push_back(res);
            end
            if (batch.size() > 0) begin
                batch[batch.size() - 1].fin = 1'b1;
            end
            foreach (batch[i]) begin
                awaited_results.push_back(batch[i]);
            end
        end
    endfunction

    always @(posedge clk) begin : check_results
        ring_result_t want;
        if (rst_n && out_valid && out_ready) begin
            if (awaited_results.size() == 0) begin
                note_failure($sformatf("unexpected result: kind=%0d status=%0d cookie=%h last=%0d",
                                       result_kind, status, done_cookie, last));
            end else begin
                want = awaited_results.pop_front();
                if (result_kind !== want.rkind || status !== want.st
                    || done_cookie !== want.tag || last !== want.fin) begin
                    note_failure($sformatf({"result mismatch: expected kind=%0d status=%0d ",
                                            "cookie=%h last=%0d, got kind=%0d status=%0d ",
                                            "cookie=%h last=%0d"},
                                           want.rkind, want.st, want.tag, want.fin,
                                           result_kind, status, done_cookie, last));
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin : receiver
        int wait_cycles;
        out_ready = 1'b0;
        while (rst_n !== 1'b1) begin
            @(posedge clk);
        end
        forever begin
            wait_cycles     = no_gaps ? 0 : $urandom_range(0, 4);
            wait_cycles     = wait_cycles + hold_off_cycles;
            hold_off_cycles = 0;
            if (wait_cycles > 0) begin
                out_ready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            out_ready <= 1'b1;
            do begin
                @(posedge clk);
            end while (!(out_valid && out_ready));
        end
    end

    task automatic send_req(input ring_req_t r);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        kind         <= r.kind;
        now_ns       <= r.now;
        cookie       <= r.tag;
        namespace_id <= r.nsid;
        poll_shard   <= r.shard;
        do begin
            @(posedge clk);
        end while (!in_ready);
        predict_ring_results(r);
    endtask

    task automatic send_issue(input logic [63:0] now, input logic [63:0] tag,
                              input logic [7:0] nsid);
        ring_req_t r;
        r.kind  = KIND_ISSUE;
        r.now   = now;
        r.tag   = tag;
        r.nsid  = nsid;
        r.shard = 3'($urandom);
        send_req(r);
    endtask

    task automatic send_poll(input logic [63:0] now, input logic [2:0] shard);
        ring_req_t r;
        r.kind  = KIND_POLL;
        r.now   = now;
        r.tag   = {$urandom, $urandom};
        r.nsid  = 8'($urandom);
        r.shard = shard;
        send_req(r);
    endtask

    task automatic settle();
        while (awaited_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic program_regs(input logic [31:0] lat, drop, err, cnt, mask);
        logic [2:0]  ids [5];
        logic [31:0] vals [5];
        ids  = '{CFG_READ_LATENCY, CFG_DROP_PPM, CFG_ERROR_PPM, CFG_NS_COUNT, CFG_NS_MASK};
        vals = '{lat, drop, err, cnt, mask};
        in_valid <= 1'b0;
        settle();
        for (int i = 0; i < 5; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= ids[i];
            cfg_data  <= vals[i];
            do begin
                @(posedge clk);
            end while (!cfg_ready);
            case (ids[i])
                CFG_READ_LATENCY: lat_cfg      = vals[i];
                CFG_DROP_PPM:     drop_cfg     = vals[i][19:0];
                CFG_ERROR_PPM:    err_cfg      = vals[i][19:0];
                CFG_NS_COUNT:     ns_count_cfg = vals[i][5:0];
                CFG_NS_MASK:      ns_mask_cfg  = vals[i];
                default:          ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_all();
        for (int s = 0; s < NUM_SHARDS; s++) begin
            send_poll(TIME_MAX, 3'(s));
        end
    endtask

    task automatic run_traffic(input int count, input int noise_pct);
        ring_req_t r;
        int        pick;
        sim_ns = {$urandom, $urandom};
        for (int i = 0; i < count; i++) begin
            pick    = $urandom_range(0, 99);
            r.kind  = KIND_ISSUE;
            r.now   = sim_ns;
            r.tag   = {$urandom, $urandom};
            r.nsid  = 8'($urandom);
            r.shard = 3'($urandom);
            if (pick < noise_pct) begin
                r.kind = 1'($urandom);
                r.now  = {$urandom, $urandom};
            end else if (pick < noise_pct + 35) begin
                r.kind = KIND_POLL;
            end else begin
                r.tag[63:32] = 32'($urandom_range(0, NUM_SHARDS - 1));
                if (ns_count_cfg != 0) begin
                    r.nsid = 8'($urandom_range(0, ns_count_cfg - 1));
                end
            end
            send_req(r);
            sim_ns = sim_ns + 64'($urandom_range(0, 40));
        end
        drain_all();
    endtask

    task automatic test_reset_values();
        send_issue(64'd0, 64'd0, 8'd0);
        send_issue(64'd1, '1, 8'd0);
        send_poll(64'd0, 3'd0);
    endtask

    task automatic test_issue_checks();
        program_regs(0, 0, 0, 32, '1);
        send_issue(64'd0, 64'd0, 8'd0);
        send_issue(TIME_MAX, {32'd7, 32'hFFFF_FFFF}, 8'd31);
        send_issue(64'd5, {32'd8, 32'd0}, 8'd0);
        send_issue(64'd5, '1, 8'd255);
        send_issue(64'd5, {32'd1, 32'h1234_5678}, 8'd32);
        send_issue(64'd5, {32'd1, 32'h8765_4321}, 8'd255);
        send_poll(64'd0, 3'd0);
        send_poll(TIME_MAX, 3'd7);
        send_poll(TIME_MAX, 3'd7);
    endtask

    task automatic test_namespace_and_wrap();
        program_regs('1, 0, 0, 5, 32'h0000_0015);
        send_issue(64'hFFFF_FFFF_FFFF_FFF0, {32'd2, 32'hAAAA_5555}, 8'd4);
        send_issue(64'd6, {32'd2, 32'd1}, 8'd1);
        send_issue(64'd6, {32'd2, 32'd2}, 8'd5);
        send_issue(64'd0, {32'd2, 32'h5555_AAAA}, 8'd0);
        send_poll(64'hFFFF_FFEE, 3'd2);
        send_poll(64'hFFFF_FFFF, 3'd2);
    endtask

    task automatic test_fault_extremes();
        program_regs(0, 1000000, 0, 32, '1);
        send_issue(64'd10, {32'd4, $urandom}, 8'd3);
        send_issue(64'd11, {32'd4, $urandom}, 8'd3);
        send_poll(64'd11, 3'd4);
        program_regs(0, 0, 32'h000F_FFFF, 32, '1);
        send_issue(64'd20, {32'd5, $urandom}, 8'd9);
        send_issue(64'd21, {32'd5, $urandom}, 8'd9);
        send_poll(64'd30, 3'd5);
    endtask

    task automatic test_ring_full();
        program_regs($urandom_range(0, 100), 0, 0, 32, '1);
        sim_ns = 64'd0;
        repeat (RING_DEPTH) begin
            send_issue(sim_ns, {32'd3, $urandom}, 8'($urandom_range(0, 31)));
            sim_ns = sim_ns + 64'($urandom_range(0, 20));
        end
        send_issue(sim_ns, {32'd3, $urandom}, 8'd200);
        send_issue(sim_ns, {32'd3, $urandom}, 8'd0);
        send_issue(sim_ns, {32'd9, $urandom}, 8'd200);
        send_poll(TIME_MAX, 3'd3);
    endtask

    task automatic test_receiver_stall();
        program_regs($urandom_range(0, 150), 0, 0, 32, $urandom | $urandom);
        hold_off_cycles = HOLD_OFF_CYCLES;
        run_traffic(130, 10);
    endtask

    task automatic test_back_to_back();
        program_regs($urandom_range(0, 150), $urandom_range(0, 200000),
                     $urandom_range(0, 200000), $urandom_range(16, 32), '1);
        no_gaps = 1'b1;
        run_traffic(120, 5);
        no_gaps = 1'b0;
    endtask

    task automatic test_random_faults();
        program_regs($urandom_range(0, 150), $urandom_range(0, 400000),
                     $urandom_range(0, 400000), $urandom_range(0, 32), $urandom);
        run_traffic(130, 15);
    endtask

    task automatic test_long_latency();
        program_regs($urandom | 32'h8000_0000, $urandom_range(0, 100000),
                     $urandom_range(0, 100000), 32, $urandom | $urandom);
        run_traffic(100, 10);
    endtask

    initial begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        kind         = KIND_ISSUE;
        now_ns       = '0;
        cookie       = '0;
        namespace_id = '0;
        poll_shard   = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_READ_LATENCY;
        cfg_data     = '0;
        foreach (head_q[i]) begin
            head_q[i] = '0;
            tail_q[i] = '0;
        end
        roll_state   = 32'd1;
        lat_cfg      = '0;
        drop_cfg     = '0;
        err_cfg      = '0;
        ns_count_cfg = '0;
        ns_mask_cfg  = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_issue_checks();
        test_namespace_and_wrap();
        test_fault_extremes();
        test_ring_full();
        test_receiver_stall();
        test_back_to_back();
        test_random_faults();
        test_long_latency();
        in_valid <= 1'b0;
        settle();
        if (mismatches == 0 && awaited_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
